### sv/ttt_pkg.sv
// Package for the task timer table: opcodes, status codes, widths and the
// structs that travel along the cell chain. No dependencies.
package ttt_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int IDX_W         = 5;
    localparam int TOTAL_W       = 13;
    localparam int FREE_W        = 6;

    typedef enum logic [2:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_ARM        = 3'd2,
        OP_SET_SCR    = 3'd3,
        OP_SCAN       = 3'd4,
        OP_SELECT     = 3'd5,
        OP_QUERY      = 3'd6,
        OP_UNUSED     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NONE      = 2'd3
    } status_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [7:0]         id;
        logic [7:0]         pos;
        logic [31:0]        now;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [7:0]         hit_scr;
        logic               empty_found;
        logic [IDX_W-1:0]   empty_idx;
        logic [7:0]         empty_scr;
        logic [TOTAL_W-1:0] sum;
        logic               sel_found;
        logic [IDX_W-1:0]   sel_idx;
        logic [7:0]         sel_task;
        logic [7:0]         sel_minor;
    } wave_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [7:0]       task_id;
    } report_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             set_task;
        logic [7:0]       task_id;
        logic             set_dl;
        logic [31:0]      deadline;
        logic             set_scr;
        logic [7:0]       screens;
    } wr_t;

endpackage

### sv/ttt_cell.sv
// One slot of the task timer table: holds task id, deadline and screen count,
// updates the passing item record and registers it for the next cell.
// Depends on ttt_pkg.
module ttt_cell #(
    parameter int MY_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ttt_pkg::wave_t   wave_in,
    input  ttt_pkg::wr_t     wr,
    output ttt_pkg::wave_t   wave_out,
    output ttt_pkg::report_t rep
);

    localparam logic [ttt_pkg::IDX_W-1:0] IDX = ttt_pkg::IDX_W'(MY_IDX);

    logic [7:0]     task_reg;
    logic [31:0]    dl_reg;
    logic [7:0]     scr_reg;
    ttt_pkg::wave_t wave_reg;
    ttt_pkg::wave_t wave_next;
    logic           occupied;
    logic [13:0]    upper;

    assign occupied = (task_reg != 8'd0);
    assign upper    = {1'b0, wave_in.sum} + {6'd0, scr_reg};

    always_comb
    begin
        wave_next = wave_in;
        rep       = '0;
        if (wave_in.valid)
        begin
            if (!wave_in.hit && task_reg == wave_in.id)
            begin
                wave_next.hit     = 1'b1;
                wave_next.hit_idx = IDX;
                wave_next.hit_scr = scr_reg;
            end
            if (!wave_in.empty_found && !occupied)
            begin
                wave_next.empty_found = 1'b1;
                wave_next.empty_idx   = IDX;
                wave_next.empty_scr   = scr_reg;
            end
            if (occupied && !wave_in.sel_found)
            begin
                if (upper > {6'd0, wave_in.pos})
                begin
                    wave_next.sel_found = 1'b1;
                    wave_next.sel_idx   = IDX;
                    wave_next.sel_task  = task_reg;
                    wave_next.sel_minor = wave_in.pos - wave_in.sum[7:0];
                end
                else
                begin
                    wave_next.sum = upper[ttt_pkg::TOTAL_W-1:0];
                end
            end
            if (wave_in.op == ttt_pkg::OP_SCAN && occupied && dl_reg != 32'd0
                && dl_reg < wave_in.now)
            begin
                rep.valid   = 1'b1;
                rep.idx     = IDX;
                rep.task_id = task_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_reg <= 8'd0;
            dl_reg   <= 32'd0;
            scr_reg  <= 8'd0;
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
            if (rep.valid)
            begin
                dl_reg <= 32'd0;
            end
            if (wr.en && wr.idx == IDX)
            begin
                if (wr.set_task)
                begin
                    task_reg <= wr.task_id;
                end
                if (wr.set_dl)
                begin
                    dl_reg <= wr.deadline;
                end
                if (wr.set_scr)
                begin
                    scr_reg <= wr.screens;
                end
            end
        end
    end

    assign wave_out = wave_reg;

endmodule

### sv/task_timer_table_unit.sv
// Task timer table top level: slot cell chain, sequencer and result registers; needs ttt_pkg.
// Query, unused-opcode and zero-id items other than scan or select answer in the cycle after
// start; other items pass the injection register, sweep the chain one cell per cycle and
// register their final result. A scan holds each due report until the next one is found or
// the sweep ends, at most one per cycle. A sweep blocks new items; immediate answers run back
// to back; the receiver cannot stall. Reset empties and disarms all slots and clears the screens.
module task_timer_table_unit #(
    parameter int SLOTS = ttt_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic [7:0]                  task_id,
    input  logic [31:0]                 delay_ms,
    input  logic [7:0]                  screens,
    input  logic [7:0]                  screen_position,
    input  logic [31:0]                 now_ms,
    output logic                        valid,
    output logic [1:0]                  status,
    output logic [ttt_pkg::IDX_W-1:0]   slot_index,
    output logic [7:0]                  task_id_out,
    output logic [7:0]                  minor_screen,
    output logic [ttt_pkg::TOTAL_W-1:0] screen_total,
    output logic [ttt_pkg::FREE_W-1:0]  free_slots,
    output logic                        due,
    output logic                        last
);

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } state_t;

    state_t                      state_reg, state_next;
    ttt_pkg::wave_t              inj_reg, inj_next;
    logic [31:0]                 delay_reg;
    logic [7:0]                  scr_reg;
    logic [ttt_pkg::FREE_W-1:0]  used_reg, used_next;
    logic [ttt_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [ttt_pkg::IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [7:0]                  pend_task_reg, pend_task_next;

    logic                        valid_reg;
    ttt_pkg::status_t            status_reg;
    logic [ttt_pkg::IDX_W-1:0]   slot_reg;
    logic [7:0]                  task_out_reg;
    logic [7:0]                  minor_reg;
    logic [ttt_pkg::TOTAL_W-1:0] total_out_reg;
    logic [ttt_pkg::FREE_W-1:0]  free_reg;
    logic                        due_reg;
    logic                        last_reg;

    logic                        emit;
    ttt_pkg::status_t            e_status;
    logic [ttt_pkg::IDX_W-1:0]   e_slot;
    logic [7:0]                  e_task;
    logic [7:0]                  e_minor;
    logic                        e_due;
    logic                        e_last;

    ttt_pkg::wave_t              chain [SLOTS+1];
    ttt_pkg::report_t            reps  [SLOTS];
    ttt_pkg::report_t            rep_any;
    ttt_pkg::wr_t                wr;
    ttt_pkg::wave_t              w;
    ttt_pkg::op_t                op_in;

    assign chain[0] = inj_reg;
    assign w        = chain[SLOTS];
    assign op_in    = ttt_pkg::op_t'(opcode);

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ttt_cell #(
            .MY_IDX(g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wave_in  (chain[g]),
            .wr       (wr),
            .wave_out (chain[g+1]),
            .rep      (reps[g])
        );
    end

    always_comb
    begin
        rep_any = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rep_any = rep_any | reps[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        inj_next        = '0;
        used_next       = used_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_task_next  = pend_task_reg;
        wr              = '0;
        emit            = 1'b0;
        e_status        = ttt_pkg::ST_OK;
        e_slot          = '0;
        e_task          = 8'd0;
        e_minor         = 8'd0;
        e_due           = 1'b0;
        e_last          = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op_in == ttt_pkg::OP_QUERY)
                    begin
                        emit = 1'b1;
                    end
                    else if (op_in == ttt_pkg::OP_UNUSED
                             || (op_in <= ttt_pkg::OP_SET_SCR && task_id == 8'd0))
                    begin
                        emit     = 1'b1;
                        e_status = ttt_pkg::ST_NONE;
                    end
                    else
                    begin
                        inj_next.valid  = 1'b1;
                        inj_next.op     = op_in;
                        inj_next.id     = task_id;
                        inj_next.pos    = screen_position;
                        inj_next.now    = now_ms;
                        pend_valid_next = 1'b0;
                        state_next      = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (rep_any.valid)
                begin
                    if (pend_valid_reg)
                    begin
                        emit   = 1'b1;
                        e_slot = pend_idx_reg;
                        e_task = pend_task_reg;
                        e_due  = 1'b1;
                        e_last = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rep_any.idx;
                    pend_task_next  = rep_any.task_id;
                end
                if (w.valid)
                begin
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    unique case (w.op) inside
                        ttt_pkg::OP_REGISTER:
                        begin
                            if (w.hit)
                            begin
                                wr.en     = 1'b1;
                                wr.idx    = w.hit_idx;
                                wr.set_dl = 1'b1;
                                e_slot    = w.hit_idx;
                            end
                            else if (w.empty_found)
                            begin
                                wr.en       = 1'b1;
                                wr.idx      = w.empty_idx;
                                wr.set_dl   = 1'b1;
                                wr.set_task = 1'b1;
                                wr.task_id  = w.id;
                                used_next   = used_reg + ttt_pkg::FREE_W'(1);
                                total_next  = total_reg
                                    + {{(ttt_pkg::TOTAL_W-8){1'b0}}, w.empty_scr};
                                e_slot      = w.empty_idx;
                            end
                            else
                            begin
                                e_status = ttt_pkg::ST_FULL;
                            end
                        end
                        ttt_pkg::OP_UNREGISTER, ttt_pkg::OP_ARM, ttt_pkg::OP_SET_SCR:
                        begin
                            if (!w.hit)
                            begin
                                e_status = ttt_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                wr.en  = 1'b1;
                                wr.idx = w.hit_idx;
                                e_slot = w.hit_idx;
                                if (w.op == ttt_pkg::OP_UNREGISTER)
                                begin
                                    wr.set_task = 1'b1;
                                    wr.set_dl   = 1'b1;
                                    if (used_reg != '0)
                                    begin
                                        used_next = used_reg - ttt_pkg::FREE_W'(1);
                                    end
                                    total_next = total_reg
                                        - {{(ttt_pkg::TOTAL_W-8){1'b0}}, w.hit_scr};
                                end
                                else if (w.op == ttt_pkg::OP_ARM)
                                begin
                                    wr.set_dl   = 1'b1;
                                    wr.deadline = (delay_reg != 32'd0)
                                        ? w.now + delay_reg : 32'd0;
                                end
                                else
                                begin
                                    wr.set_scr = 1'b1;
                                    wr.screens = scr_reg;
                                    total_next = total_reg
                                        - {{(ttt_pkg::TOTAL_W-8){1'b0}}, w.hit_scr}
                                        + {{(ttt_pkg::TOTAL_W-8){1'b0}}, scr_reg};
                                end
                            end
                        end
                        ttt_pkg::OP_SCAN:
                        begin
                            if (pend_valid_reg)
                            begin
                                e_slot = pend_idx_reg;
                                e_task = pend_task_reg;
                                e_due  = 1'b1;
                            end
                            else
                            begin
                                e_status = ttt_pkg::ST_NONE;
                            end
                            pend_valid_next = 1'b0;
                        end
                        ttt_pkg::OP_SELECT:
                        begin
                            if (w.sel_found)
                            begin
                                e_slot  = w.sel_idx;
                                e_task  = w.sel_task;
                                e_minor = w.sel_minor;
                            end
                            else
                            begin
                                e_status = ttt_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            e_status = ttt_pkg::ST_NONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            inj_reg        <= '0;
            delay_reg      <= 32'd0;
            scr_reg        <= 8'd0;
            used_reg       <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            pend_task_reg  <= 8'd0;
            valid_reg      <= 1'b0;
            status_reg     <= ttt_pkg::ST_OK;
            slot_reg       <= '0;
            task_out_reg   <= 8'd0;
            minor_reg      <= 8'd0;
            total_out_reg  <= '0;
            free_reg       <= '0;
            due_reg        <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            inj_reg        <= inj_next;
            used_reg       <= used_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            pend_task_reg  <= pend_task_next;
            valid_reg      <= emit;
            if (state_reg == S_IDLE && start)
            begin
                delay_reg <= delay_ms;
                scr_reg   <= screens;
            end
            if (emit)
            begin
                status_reg    <= e_status;
                slot_reg      <= e_slot;
                task_out_reg  <= e_task;
                minor_reg     <= e_minor;
                total_out_reg <= total_next;
                free_reg      <= ttt_pkg::FREE_W'(SLOTS) - used_next;
                due_reg       <= e_due;
                last_reg      <= e_last;
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign valid        = valid_reg;
    assign status       = status_reg;
    assign slot_index   = slot_reg;
    assign task_id_out  = task_out_reg;
    assign minor_screen = minor_reg;
    assign screen_total = total_out_reg;
    assign free_slots   = free_reg;
    assign due          = due_reg;
    assign last         = last_reg;

endmodule

### dv/task_timer_table_unit_tb.sv
// Self-checking testbench for task_timer_table_unit: a directed table followed by
// random item streams; each result is checked against a cycle-free table predictor, or against
// a fixed result on some directed rows. Depends on ttt_pkg and the task_timer_table_unit RTL.
module task_timer_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS            = ttt_pkg::SLOTS_DEFAULT;
    localparam int DIRECTED_ROWS    = 28;
    localparam int ITEMS_PER_PHASE  = 113;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int IDLE_PCT [4]     = '{0, 54, 0, 27};

    typedef struct packed {
        ttt_pkg::status_t            status;
        logic [ttt_pkg::IDX_W-1:0]   slot;
        logic [7:0]                  tid;
        logic [7:0]                  minor;
        logic [ttt_pkg::TOTAL_W-1:0] total;
        logic [ttt_pkg::FREE_W-1:0]  free;
        logic                        due;
        logic                        last;
    } timer_result_t;

    typedef struct {
        ttt_pkg::op_t  op;
        logic [7:0]    id;
        logic [31:0]   delay;
        logic [7:0]    scr;
        logic [7:0]    pos;
        logic [31:0]   now;
        bit            has_fixed;
        timer_result_t fixed_result;
    } timer_cmd_t;

    localparam timer_result_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  opcode = '0;
    logic [7:0]  task_id = '0;
    logic [31:0] delay_ms = '0;
    logic [7:0]  screens = '0;
    logic [7:0]  screen_position = '0;
    logic [31:0] now_ms = '0;

    logic                        busy;
    logic                        valid;
    logic [1:0]                  status;
    logic [ttt_pkg::IDX_W-1:0]   slot_index;
    logic [7:0]                  task_id_out;
    logic [7:0]                  minor_screen;
    logic [ttt_pkg::TOTAL_W-1:0] screen_total;
    logic [ttt_pkg::FREE_W-1:0]  free_slots;
    logic                        due;
    logic                        last;

    logic [7:0]  model_task [SLOTS];
    logic [31:0] model_deadline [SLOTS];
    logic [7:0]  model_screens [SLOTS];
    int          model_used;

    timer_result_t expected_results [$];
    timer_cmd_t    directed_rows [DIRECTED_ROWS];
    logic [31:0]   wall_ms = 32'd0;
    int            errors = 0;
    int            stall_cycles = 0;

    task_timer_table_unit #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .task_id(task_id),
        .delay_ms(delay_ms),
        .screens(screens),
        .screen_position(screen_position),
        .now_ms(now_ms),
        .valid(valid),
        .status(status),
        .slot_index(slot_index),
        .task_id_out(task_id_out),
        .minor_screen(minor_screen),
        .screen_total(screen_total),
        .free_slots(free_slots),
        .due(due),
        .last(last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic timer_result_t quiet_result(ttt_pkg::status_t st, int free_count);
        timer_result_t r;
        r        = '0;
        r.status = st;
        r.free   = ttt_pkg::FREE_W'(free_count);
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic timer_result_t table_snapshot(ttt_pkg::status_t st, int slot,
                                                     logic [7:0] tid, logic [7:0] minor,
                                                     logic is_due);
        timer_result_t r;
        int total;
        total = 0;
        for (int i = 0; i < SLOTS; i++)
            if (model_task[i] != 8'd0)
                total += int'(model_screens[i]);
        r.status = st;
        r.slot   = ttt_pkg::IDX_W'(slot);
        r.tid    = tid;
        r.minor  = minor;
        r.total  = ttt_pkg::TOTAL_W'(total);
        r.free   = ttt_pkg::FREE_W'(SLOTS - model_used);
        r.due    = is_due;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic int find_slot(logic [7:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (model_task[i] == id)
                return i;
        return -1;
    endfunction

    task automatic predict_item(input timer_cmd_t c);
        int idx;
        int sum;
        int hit;
        int reported;
        timer_result_t tail;
        if (c.op <= ttt_pkg::OP_SET_SCR && c.id == 8'd0)
        begin
            expected_results.push_back(table_snapshot(ttt_pkg::ST_NONE, 0, 8'd0, 8'd0, 1'b0));
        end
        else
        begin
            unique case (c.op) inside
                ttt_pkg::OP_REGISTER:
                begin
                    idx = find_slot(c.id);
                    if (idx >= 0)
                    begin
                        model_deadline[idx] = 32'd0;
                        expected_results.push_back(
                            table_snapshot(ttt_pkg::ST_OK, idx, 8'd0, 8'd0, 1'b0));
                    end
                    else
                    begin
                        idx = find_slot(8'd0);
                        if (idx < 0)
                        begin
                            expected_results.push_back(
                                table_snapshot(ttt_pkg::ST_FULL, 0, 8'd0, 8'd0, 1'b0));
                        end
                        else
                        begin
                            model_task[idx]     = c.id;
                            model_deadline[idx] = 32'd0;
                            model_used++;
                            expected_results.push_back(
                                table_snapshot(ttt_pkg::ST_OK, idx, 8'd0, 8'd0, 1'b0));
                        end
                    end
                end
                ttt_pkg::OP_UNREGISTER, ttt_pkg::OP_ARM, ttt_pkg::OP_SET_SCR:
                begin
                    idx = find_slot(c.id);
                    if (idx < 0)
                    begin
                        expected_results.push_back(
                            table_snapshot(ttt_pkg::ST_NOT_FOUND, 0, 8'd0, 8'd0, 1'b0));
                    end
                    else
                    begin
                        if (c.op == ttt_pkg::OP_UNREGISTER)
                        begin
                            model_task[idx]     = 8'd0;
                            model_deadline[idx] = 32'd0;
                            if (model_used > 0)
                                model_used--;
                        end
                        else if (c.op == ttt_pkg::OP_ARM)
                        begin
                            model_deadline[idx] = (c.delay != 32'd0) ? c.now + c.delay : 32'd0;
                        end
                        else
                        begin
                            model_screens[idx] = c.scr;
                        end
                        expected_results.push_back(
                            table_snapshot(ttt_pkg::ST_OK, idx, 8'd0, 8'd0, 1'b0));
                    end
                end
                ttt_pkg::OP_SCAN:
                begin
                    reported = 0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (model_task[i] != 8'd0 && model_deadline[i] != 32'd0 &&
                            model_deadline[i] < c.now)
                        begin
                            model_deadline[i] = 32'd0;
                            expected_results.push_back(
                                table_snapshot(ttt_pkg::ST_OK, i, model_task[i], 8'd0, 1'b1));
                            reported++;
                        end
                    end
                    if (reported == 0)
                        expected_results.push_back(
                            table_snapshot(ttt_pkg::ST_NONE, 0, 8'd0, 8'd0, 1'b0));
                end
                ttt_pkg::OP_SELECT:
                begin
                    sum = 0;
                    hit = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (model_task[i] == 8'd0)
                            continue;
                        if (sum + int'(model_screens[i]) > int'(c.pos))
                        begin
                            hit = i;
                            break;
                        end
                        sum += int'(model_screens[i]);
                    end
                    if (hit < 0)
                        expected_results.push_back(
                            table_snapshot(ttt_pkg::ST_NOT_FOUND, 0, 8'd0, 8'd0, 1'b0));
                    else
                        expected_results.push_back(
                            table_snapshot(ttt_pkg::ST_OK, hit, model_task[hit],
                                           8'(int'(c.pos) - sum), 1'b0));
                end
                ttt_pkg::OP_QUERY:
                    expected_results.push_back(
                        table_snapshot(ttt_pkg::ST_OK, 0, 8'd0, 8'd0, 1'b0));
                default:
                    expected_results.push_back(
                        table_snapshot(ttt_pkg::ST_NONE, 0, 8'd0, 8'd0, 1'b0));
            endcase
        end
        tail = expected_results.pop_back();
        tail.last = 1'b1;
        expected_results.push_back(tail);
    endtask

    function automatic timer_cmd_t random_cmd();
        timer_cmd_t c;
        int roll;
        c = '{ttt_pkg::OP_QUERY, 8'd0, 32'd0, 8'd0, 8'd0, 32'd0, 1'b0, NO_RESULT};
        roll = $urandom_range(99);
        if (roll < 18)
            c.op = ttt_pkg::OP_REGISTER;
        else if (roll < 28)
            c.op = ttt_pkg::OP_UNREGISTER;
        else if (roll < 50)
            c.op = ttt_pkg::OP_ARM;
        else if (roll < 60)
            c.op = ttt_pkg::OP_SET_SCR;
        else if (roll < 80)
            c.op = ttt_pkg::OP_SCAN;
        else if (roll < 90)
            c.op = ttt_pkg::OP_SELECT;
        else if (roll < 97)
            c.op = ttt_pkg::OP_QUERY;
        else
            c.op = ttt_pkg::OP_UNUSED;
        roll = $urandom_range(99);
        if (roll < 85)
            c.id = 8'($urandom_range(1, 12));
        else if (roll < 93)
            c.id = 8'($urandom_range(255));
        else
            c.id = 8'd0;
        roll = $urandom_range(99);
        if (roll < 10)
            c.delay = 32'd0;
        else if (roll < 80)
            c.delay = $urandom_range(1, 200);
        else
            c.delay = $urandom;
        c.scr = ($urandom_range(1) == 0) ? 8'($urandom_range(40)) : 8'($urandom_range(255));
        c.pos = ($urandom_range(1) == 0) ? 8'($urandom_range(80)) : 8'($urandom_range(255));
        if ($urandom_range(99) < 3)
            wall_ms = $urandom;
        else
            wall_ms = wall_ms + $urandom_range(0, 40);
        c.now = ($urandom_range(99) < 5) ? $urandom : wall_ms;
        return c;
    endfunction

    task automatic issue_item(input timer_cmd_t c, input int idle_pct);
        int mark;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        opcode          <= c.op;
        task_id         <= c.id;
        delay_ms        <= c.delay;
        screens         <= c.scr;
        screen_position <= c.pos;
        now_ms          <= c.now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mark = expected_results.size();
        predict_item(c);
        if (c.has_fixed)
        begin
            while (expected_results.size() > mark)
                void'(expected_results.pop_back());
            expected_results.push_back(c.fixed_result);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v,
                     got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, status, slot_index);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("slot_index", 32'(want.slot), 32'(slot_index));
                check_field("task_id_out", 32'(want.tid), 32'(task_id_out));
                check_field("minor_screen", 32'(want.minor), 32'(minor_screen));
                check_field("screen_total", 32'(want.total), 32'(screen_total));
                check_field("free_slots", 32'(want.free), 32'(free_slots));
                check_field("due", 32'(want.due), 32'(due));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("task_timer_table_unit_tb: errors");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            model_task[i]     = 8'd0;
            model_deadline[i] = 32'd0;
            model_screens[i]  = 8'd0;
        end
        model_used = 0;

        directed_rows = '{
            '{ttt_pkg::OP_QUERY,      8'd0,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_OK, 8)},
            '{ttt_pkg::OP_SCAN,       8'd0,   32'd0,         8'd0,   8'd0,   32'hFFFF_FFFF,
              1'b1, quiet_result(ttt_pkg::ST_NONE, 8)},
            '{ttt_pkg::OP_REGISTER,   8'd0,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_NONE, 8)},
            '{ttt_pkg::OP_ARM,        8'd0,   32'd5,         8'd0,   8'd0,   32'd100,
              1'b1, quiet_result(ttt_pkg::ST_NONE, 8)},
            '{ttt_pkg::OP_UNREGISTER, 8'd5,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_NOT_FOUND, 8)},
            '{ttt_pkg::OP_SET_SCR,    8'd5,   32'd0,         8'd9,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_NOT_FOUND, 8)},
            '{ttt_pkg::OP_SELECT,     8'd0,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_NOT_FOUND, 8)},
            '{ttt_pkg::OP_UNUSED,     8'd255, 32'hFFFF_FFFF, 8'd255, 8'd255, 32'hFFFF_FFFF,
              1'b1, quiet_result(ttt_pkg::ST_NONE, 8)},
            '{ttt_pkg::OP_REGISTER,   8'd255, 32'd0,         8'd0,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_OK, 7)},
            '{ttt_pkg::OP_REGISTER,   8'd1,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd2,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd3,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd4,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd5,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd6,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd7,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd200, 32'd0,         8'd0,   8'd0,   32'd0,
              1'b1, quiet_result(ttt_pkg::ST_FULL, 0)},
            '{ttt_pkg::OP_REGISTER,   8'd255, 32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_SET_SCR,    8'd255, 32'd0,         8'd255, 8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_SET_SCR,    8'd1,   32'd0,         8'd255, 8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_ARM,        8'd255, 32'hFFFF_FFFF, 8'd0,   8'd0,   32'd1,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_ARM,        8'd1,   32'hFFFF_FFFF, 8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_ARM,        8'd2,   32'd1,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_ARM,        8'd3,   32'd5,         8'd0,   8'd0,   32'hFFFF_FFF0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_SCAN,       8'd0,   32'd0,         8'd0,   8'd0,   32'hFFFF_FFFF,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_SELECT,     8'd0,   32'd0,         8'd0,   8'd255, 32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_UNREGISTER, 8'd255, 32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT},
            '{ttt_pkg::OP_REGISTER,   8'd9,   32'd0,         8'd0,   8'd0,   32'd0,
              1'b0, NO_RESULT}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_item(directed_rows[i], 0);

        wall_ms = $urandom_range(1000);
        for (int phase = 0; phase < 4; phase++)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (expected_results.size() != 0)
                @(posedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                issue_item(random_cmd(), IDLE_PCT[phase]);
        end
        start <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
        if (errors == 0)
            $display("task_timer_table_unit_tb: clean");
        else
            $display("task_timer_table_unit_tb: errors");
        $finish;
    end
endmodule

### files.f
sv/ttt_pkg.sv
sv/ttt_cell.sv
sv/task_timer_table_unit.sv
dv/task_timer_table_unit_tb.sv
